/* sv/gbma_pkg.sv */
package gbma_pkg;

    localparam int RAW_W     = 16;
    localparam int FS_W      = 3;
    localparam int BIAS_W    = 27;
    localparam int CORR_W    = 29;
    localparam int AVG_W     = 28;
    localparam int SCALE_NUM = 2000;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [FS_W-1:0]          FS_RESET     = 3'd1;
    localparam logic signed [BIAS_W-1:0] BIAS_X_RESET = -27'sd44237;
    localparam logic signed [BIAS_W-1:0] BIAS_Y_RESET = -27'sd6226;
    localparam logic signed [BIAS_W-1:0] BIAS_Z_RESET = -27'sd11796;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_FULL_SCALE = 2'd0,
        REG_BIAS_X     = 2'd1,
        REG_BIAS_Y     = 2'd2,
        REG_BIAS_Z     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [FS_W-1:0]          full_scale_code;
        logic signed [BIAS_W-1:0] bias_x;
        logic signed [BIAS_W-1:0] bias_y;
        logic signed [BIAS_W-1:0] bias_z;
    } cfg_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } sample_t;

    typedef struct packed {
        logic signed [AVG_W-1:0] avg_x;
        logic signed [AVG_W-1:0] avg_y;
        logic signed [AVG_W-1:0] avg_z;
    } result_t;

endpackage

/* sv/gyro_bias_and_moving_average.sv */
// Channel   Direction  Handshake                       Payload
// sample    in         sample_valid / sample_ready     gbma_pkg::sample_t (raw_x/y/z)
// result    out        result_valid / result_ready     gbma_pkg::result_t (avg_x/y/z)
// config    in         APB psel/penable/pwrite, pready gbma_pkg::cfg_t registers
//
// One item is accepted per clock while the result is taken or a stage is
// empty; each item passes through a five-register pipeline: input, scaled
// sample, window sum, split reciprocal product, quotient.
// Reset clears the pipeline, the window sums, the write slot and the ring's
// fill flag at once; there is no clearing pass over the ring.
// A stalled result only holds the stages behind it that are occupied, so
// empty stages keep taking items until the pipeline is full.
module gyro_bias_and_moving_average
#(
    parameter int HISTORY_DEPTH = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  gbma_pkg::sample_t            sample,

    output logic                         result_valid,
    input  logic                         result_ready,
    output gbma_pkg::result_t            result,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbma_pkg::PADDR_W-1:0] paddr,
    input  logic [gbma_pkg::PDATA_W-1:0] pwdata,
    output logic [gbma_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int SUM_W   = gbma_pkg::CORR_W + $clog2(HISTORY_DEPTH);
    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int STAGES  = 5;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    // Scale a raw count to 1/32768 dps and remove the bias. The arithmetic
    // right shift rounds toward minus infinity, as intended.
    function automatic logic [gbma_pkg::CORR_W-1:0] correct(
        input logic signed [gbma_pkg::RAW_W-1:0]  raw,
        input logic [gbma_pkg::FS_W-1:0]          fs,
        input logic signed [gbma_pkg::BIAS_W-1:0] bias
    );
        logic signed [gbma_pkg::CORR_W-1:0] scaled;
        scaled = $signed(gbma_pkg::CORR_W'(raw))
               * $signed(gbma_pkg::CORR_W'(gbma_pkg::SCALE_NUM));
        scaled = scaled >>> fs;
        return gbma_pkg::CORR_W'(scaled - $signed(gbma_pkg::CORR_W'(bias)));
    endfunction

    gbma_pkg::cfg_t cfg;

    // Pipeline occupancy and advance enables, one per stage.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    logic ld_corr;
    logic ld_sum;
    logic ld_prod;
    logic ld_quot;

    gbma_pkg::sample_t in_reg;
    logic [2:0][gbma_pkg::CORR_W-1:0] corr_reg;
    logic [2:0][gbma_pkg::CORR_W-1:0] corr_next;

    // Ring of past corrected samples, all three axes in one word.
    logic [2:0][gbma_pkg::CORR_W-1:0] ring_mem [HISTORY_DEPTH];
    logic [2:0][gbma_pkg::CORR_W-1:0] rd_reg;
    logic [2:0][gbma_pkg::CORR_W-1:0] old_val;

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              filled_reg;
    logic              filled_next;

    logic signed [SUM_W-1:0] sum_reg  [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic signed [gbma_pkg::AVG_W-1:0] quot [3];

    gbma_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // A stage may load when it is empty or its item moves on this cycle.
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || result_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? sample_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_ready = adv[0];
    assign result_valid = valid_reg[STAGES-1];

    assign ld_corr = adv[1] && valid_reg[0];
    assign ld_sum  = adv[2] && valid_reg[1];
    assign ld_prod = adv[3] && valid_reg[2];
    assign ld_quot = adv[4] && valid_reg[3];

    // Input register.
    always_ff @(posedge clk)
    begin
        if (sample_valid && adv[0])
        begin
            in_reg <= sample;
        end
    end

    // Scale and bias removal.
    assign corr_next[0] = correct(in_reg.raw_x, cfg.full_scale_code, cfg.bias_x);
    assign corr_next[1] = correct(in_reg.raw_y, cfg.full_scale_code, cfg.bias_y);
    assign corr_next[2] = correct(in_reg.raw_z, cfg.full_scale_code, cfg.bias_z);

    always_ff @(posedge clk)
    begin
        if (ld_corr)
        begin
            corr_reg <= corr_next;
        end
    end

    // Ring pointer and fill flag. Until the ring has wrapped once, the entry
    // being replaced has never been written and counts as zero.
    always_comb
    begin
        slot_next   = slot_reg;
        filled_next = filled_reg;
        if (ld_sum)
        begin
            if (slot_reg == LAST_SLOT)
            begin
                slot_next   = '0;
                filled_next = 1'b1;
            end
            else
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            filled_reg <= 1'b0;
        end
        else
        begin
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
        end
    end

    // The ring is read into a register, ahead of use, at the slot the next item will
    // replace. When that slot is the one written this cycle (a one-entry
    // ring), the new data is forwarded.
    always_ff @(posedge clk)
    begin
        if (ld_sum)
        begin
            ring_mem[slot_reg] <= corr_reg;
        end
        if (ld_sum && (slot_next == slot_reg))
        begin
            rd_reg <= corr_reg;
        end
        else
        begin
            rd_reg <= ring_mem[slot_next];
        end
    end

    assign old_val = filled_reg ? rd_reg : '0;

    // Running window sums: add the new sample, drop the one it replaces.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sum_next[a] = sum_reg[a]
                        + SUM_W'($signed(corr_reg[a]))
                        - SUM_W'($signed(old_val[a]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else if (ld_sum)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= sum_next[a];
            end
        end
    end

    // Division by the history depth, one unit per axis.
    for (genvar a = 0; a < 3; a++)
    begin : g_div
        gbma_div
        #(
            .HISTORY_DEPTH (HISTORY_DEPTH)
        )
        u_div
        (
            .clk     (clk),
            .ld_prod (ld_prod),
            .ld_quot (ld_quot),
            .sum     (sum_reg[a]),
            .quot    (quot[a])
        );
    end

    assign result.avg_x = quot[0];
    assign result.avg_y = quot[1];
    assign result.avg_z = quot[2];

endmodule

/* sv/gbma_cfg.sv */
module gbma_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gbma_pkg::PADDR_W-1:0]     paddr,
    input  logic [gbma_pkg::PDATA_W-1:0]     pwdata,
    output logic [gbma_pkg::PDATA_W-1:0]     prdata,
    output gbma_pkg::cfg_t                   cfg
);

    gbma_pkg::cfg_t   cfg_reg;
    gbma_pkg::cfg_t   cfg_next;
    gbma_pkg::cfg_reg_t reg_sel;
    logic             wr_en;

    assign reg_sel = gbma_pkg::cfg_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                gbma_pkg::REG_FULL_SCALE:
                    cfg_next.full_scale_code = pwdata[gbma_pkg::FS_W-1:0];
                gbma_pkg::REG_BIAS_X:
                    cfg_next.bias_x = $signed(pwdata[gbma_pkg::BIAS_W-1:0]);
                gbma_pkg::REG_BIAS_Y:
                    cfg_next.bias_y = $signed(pwdata[gbma_pkg::BIAS_W-1:0]);
                gbma_pkg::REG_BIAS_Z:
                    cfg_next.bias_z = $signed(pwdata[gbma_pkg::BIAS_W-1:0]);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale_code <= gbma_pkg::FS_RESET;
            cfg_reg.bias_x          <= gbma_pkg::BIAS_X_RESET;
            cfg_reg.bias_y          <= gbma_pkg::BIAS_Y_RESET;
            cfg_reg.bias_z          <= gbma_pkg::BIAS_Z_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Biases read back sign-extended.
    always_comb
    begin
        case (reg_sel)
            gbma_pkg::REG_FULL_SCALE:
                prdata = gbma_pkg::PDATA_W'(cfg_reg.full_scale_code);
            gbma_pkg::REG_BIAS_X:
                prdata = gbma_pkg::PDATA_W'(cfg_reg.bias_x);
            gbma_pkg::REG_BIAS_Y:
                prdata = gbma_pkg::PDATA_W'(cfg_reg.bias_y);
            gbma_pkg::REG_BIAS_Z:
                prdata = gbma_pkg::PDATA_W'(cfg_reg.bias_z);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* sv/gbma_div.sv */
// Signed division of a window sum by the history depth, truncating toward
// zero. The magnitude is multiplied by a reciprocal chosen so that the
// truncated product is exact for every magnitude that can occur; the product
// is split into two halves so that each multiplier stays narrow.
module gbma_div
#(
    parameter int HISTORY_DEPTH = 10
)
(
    input  logic                                 clk,
    input  logic                                 ld_prod,
    input  logic                                 ld_quot,
    input  logic signed [gbma_pkg::CORR_W+$clog2(HISTORY_DEPTH)-1:0] sum,
    output logic signed [gbma_pkg::AVG_W-1:0]    quot
);

    localparam int SUM_W  = gbma_pkg::CORR_W + $clog2(HISTORY_DEPTH);
    localparam int MAG_W  = SUM_W - 1;
    localparam int SHIFT  = MAG_W + $clog2(HISTORY_DEPTH);
    localparam int MUL_W  = MAG_W + 2;
    localparam int LO_W   = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = MAG_W + MUL_W;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / HISTORY_DEPTH) + 64'd1;
    localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

    logic [SUM_W-1:0]        abs_sum;
    logic [MAG_W-1:0]        mag;
    logic [LO_W+MUL_W-1:0]   lo_next;
    logic [HI_W+MUL_W-1:0]   hi_next;
    logic [LO_W+MUL_W-1:0]   lo_reg;
    logic [HI_W+MUL_W-1:0]   hi_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod;
    logic [gbma_pkg::AVG_W-1:0] q_mag;
    logic [gbma_pkg::AVG_W-1:0] quot_next;
    logic [gbma_pkg::AVG_W-1:0] quot_reg;

    // The sum is always well inside the signed range, so its magnitude fits
    // one bit less than the sum.
    assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    assign mag     = abs_sum[MAG_W-1:0];
    assign lo_next = mag[LO_W-1:0] * RECIP;
    assign hi_next = mag[MAG_W-1:LO_W] * RECIP;

    always_ff @(posedge clk)
    begin
        if (ld_prod)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            neg_reg <= sum[SUM_W-1];
        end
    end

    assign prod      = (PROD_W'(hi_reg) << LO_W) + PROD_W'(lo_reg);
    assign q_mag     = prod[SHIFT +: gbma_pkg::AVG_W];
    assign quot_next = neg_reg ? (gbma_pkg::AVG_W'(0) - q_mag) : q_mag;

    always_ff @(posedge clk)
    begin
        if (ld_quot)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = $signed(quot_reg);

endmodule
